FILE: design/tsdx_pkg.sv
// Shared types and constants for the time-series delta/XOR encoder.
package tsdx_pkg;

	localparam int TS_W    = 64;
	localparam int VAL_W   = 64;
	localparam int CNT_W   = 32;
	localparam int BYTE_W  = 8;

	// header: count, first timestamp, first value
	localparam int HDR_BITS = CNT_W + TS_W + VAL_W;
	localparam int REC_W    = HDR_BITS;
	localparam int LEN_W    = $clog2(REC_W + 1);
	localparam int ACC_W    = REC_W + BYTE_W - 1;
	localparam int ACC_CNT_W = $clog2(ACC_W + 1);

	localparam int QUEUE_DEPTH = 2;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_POINT_COUNT = 1'b0;

	// timestamp code ranges (bias, span)
	localparam logic [TS_W-1:0] R1_BIAS = 64'd63;
	localparam logic [TS_W-1:0] R2_BIAS = 64'd255;
	localparam logic [TS_W-1:0] R3_BIAS = 64'd2047;
	localparam int R1_DW = 7;
	localparam int R2_DW = 9;
	localparam int R3_DW = 12;

	// prefixes in stream order, earliest bit in bit zero
	localparam logic [1:0] T_R1_PFX   = 2'b01;
	localparam logic [2:0] T_R2_PFX   = 3'b011;
	localparam logic [3:0] T_R3_PFX   = 4'b0111;
	localparam logic [3:0] T_ESC_PFX  = 4'b1111;
	localparam logic [1:0] V_SHORT_PFX = 2'b01;
	localparam logic [1:0] V_LONG_PFX  = 2'b11;

	localparam int T_ZERO_LEN = 1;
	localparam int T_R1_LEN   = 2 + R1_DW;
	localparam int T_R2_LEN   = 3 + R2_DW;
	localparam int T_R3_LEN   = 4 + R3_DW;
	localparam int T_ESC_LEN  = 4 + TS_W;
	localparam int V_SHORT_HDR = 5;
	localparam int V_LONG_HDR  = 14;
	localparam int V_MAX_LEN   = V_LONG_HDR + VAL_W;
	localparam int V_SHORT_MAX = 5;

	typedef enum logic [2:0] {
		DOD_ZERO,
		DOD_R1,
		DOD_R2,
		DOD_R3,
		DOD_ESC
	} dod_class_t;

	typedef struct packed {
		logic [REC_W-1:0] bits;
		logic [LEN_W-1:0] len;
		logic             last;
	} rec_t;

endpackage

FILE: design/tsdx_front.sv
// Front end: accepts points, computes delta-of-delta and XOR codes, builds bit records.
module tsdx_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tsdx_pkg::CNT_W-1:0]    point_count,
	input  logic [tsdx_pkg::TS_W-1:0]     timestamp,
	input  logic [tsdx_pkg::VAL_W-1:0]    sample_bits,
	input  logic                          last_point,
	input  logic                          in_valid,
	output logic                          in_ready,
	output tsdx_pkg::rec_t                rec,
	output logic                          rec_valid,
	input  logic                          rec_ready
);

	localparam int TS_W  = tsdx_pkg::TS_W;
	localparam int VAL_W = tsdx_pkg::VAL_W;
	localparam int REC_W = tsdx_pkg::REC_W;
	localparam int LEN_W = tsdx_pkg::LEN_W;
	localparam int TC_W  = tsdx_pkg::T_ESC_LEN;
	localparam int VC_W  = tsdx_pkg::V_MAX_LEN;
	localparam int NGRP  = VAL_W / 8;
	localparam int BIT_W = $clog2(VAL_W + 1);

	function automatic logic [3:0] clz8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 0; i < 8; i++)
			if (b[i]) n = 4'(7 - i);
		return n;
	endfunction

	function automatic logic [3:0] ctz8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 7; i >= 0; i--)
			if (b[i]) n = 4'(i);
		return n;
	endfunction

	logic en1, en2, en3, en4;

	// stage 1: input register
	logic             v_s1, last_s1;
	logic [TS_W-1:0]  ts_s1;
	logic [VAL_W-1:0] val_s1;

	// stage 2: delta and XOR
	logic             v_s2, first_s2, last_s2;
	logic [TS_W-1:0]  delta_s2;
	logic [VAL_W-1:0] x_s2;

	// stage 3: delta-of-delta and per-byte zero counts
	logic                  v_s3, first_s3, last_s3;
	logic [TS_W-1:0]       dod_s3;
	logic [VAL_W-1:0]      x_s3;
	logic [NGRP-1:0][3:0]  lzg_s3, tzg_s3;

	// stage 4: classified fields
	logic                        v_s4, first_s4, last_s4, xz_s4;
	tsdx_pkg::dod_class_t        cls_s4;
	logic [TS_W-1:0]             dod_s4;
	logic [tsdx_pkg::R1_DW-1:0]  b1_s4;
	logic [tsdx_pkg::R2_DW-1:0]  b2_s4;
	logic [tsdx_pkg::R3_DW-1:0]  b3_s4;
	logic [5:0]                  lz_s4;
	logic [BIT_W-1:0]            sig_s4;
	logic [VAL_W-1:0]            shx_s4;

	logic                  have_first_q;
	logic [TS_W-1:0]       prev_ts_q, prev_delta_q;
	logic [VAL_W-1:0]      prev_val_q;

	assign en4 = !v_s4 || rec_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ts_s1   <= timestamp;
			val_s1  <= sample_bits;
			last_s1 <= last_point;
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2         <= 1'b0;
			have_first_q <= 1'b0;
			prev_ts_q    <= '0;
			prev_val_q   <= '0;
		end else if (en2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				have_first_q <= !last_s1;
				prev_ts_q    <= ts_s1;
				prev_val_q   <= val_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			first_s2 <= !have_first_q;
			last_s2  <= last_s1;
			delta_s2 <= have_first_q ? ts_s1 - prev_ts_q : ts_s1;
			x_s2     <= have_first_q ? val_s1 ^ prev_val_q : val_s1;
		end
	end

	// stage 3
	logic [NGRP-1:0][3:0] lzg_c, tzg_c;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			lzg_c[g] = clz8(x_s2[8*g +: 8]);
			tzg_c[g] = ctz8(x_s2[8*g +: 8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3         <= 1'b0;
			prev_delta_q <= '0;
		end else if (en3) begin
			v_s3 <= v_s2;
			if (v_s2)
				prev_delta_q <= first_s2 ? '0 : delta_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			first_s3 <= first_s2;
			last_s3  <= last_s2;
			dod_s3   <= first_s2 ? delta_s2 : delta_s2 - prev_delta_q;
			x_s3     <= x_s2;
			lzg_s3   <= lzg_c;
			tzg_s3   <= tzg_c;
		end
	end

	// stage 4
	logic [BIT_W-1:0]        lz_c, tz_c, tzs_c, sig_c;
	logic [TS_W-1:0]         b1_c, b2_c, b3_c;
	tsdx_pkg::dod_class_t    cls_c;

	always_comb begin
		lz_c = BIT_W'(VAL_W);
		for (int g = 0; g < NGRP; g++)
			if (lzg_s3[g] != 4'd8)
				lz_c = BIT_W'(8 * (NGRP - 1 - g)) + BIT_W'(lzg_s3[g]);
		tz_c = BIT_W'(VAL_W);
		for (int g = NGRP - 1; g >= 0; g--)
			if (tzg_s3[g] != 4'd8)
				tz_c = BIT_W'(8 * g) + BIT_W'(tzg_s3[g]);
		tzs_c = first_s3 ? '0 : tz_c;
		sig_c = BIT_W'(VAL_W) - lz_c - tz_c;

		b1_c = dod_s3 + tsdx_pkg::R1_BIAS;
		b2_c = dod_s3 + tsdx_pkg::R2_BIAS;
		b3_c = dod_s3 + tsdx_pkg::R3_BIAS;
		if (dod_s3 == '0)
			cls_c = tsdx_pkg::DOD_ZERO;
		else if (b1_c[TS_W-1:tsdx_pkg::R1_DW] == '0)
			cls_c = tsdx_pkg::DOD_R1;
		else if (b2_c[TS_W-1:tsdx_pkg::R2_DW] == '0)
			cls_c = tsdx_pkg::DOD_R2;
		else if (b3_c[TS_W-1:tsdx_pkg::R3_DW] == '0)
			cls_c = tsdx_pkg::DOD_R3;
		else
			cls_c = tsdx_pkg::DOD_ESC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			first_s4 <= first_s3;
			last_s4  <= last_s3;
			cls_s4   <= cls_c;
			dod_s4   <= dod_s3;
			b1_s4    <= b1_c[tsdx_pkg::R1_DW-1:0];
			b2_s4    <= b2_c[tsdx_pkg::R2_DW-1:0];
			b3_s4    <= b3_c[tsdx_pkg::R3_DW-1:0];
			xz_s4    <= (x_s3 == '0);
			lz_s4    <= lz_c[5:0];
			sig_s4   <= sig_c;
			shx_s4   <= x_s3 >> tzs_c;
		end
	end

	// record assembly
	logic [TC_W-1:0]  tc;
	logic [VC_W-1:0]  vc;
	logic [BIT_W:0]   tlen, vlen;
	logic [REC_W-1:0] body;

	always_comb begin
		if (xz_s4) begin
			vc   = '0;
			vlen = (BIT_W+1)'(1);
		end else if (sig_s4 <= BIT_W'(tsdx_pkg::V_SHORT_MAX)) begin
			vc   = VC_W'({shx_s4, 3'(sig_s4 - BIT_W'(1)), tsdx_pkg::V_SHORT_PFX});
			vlen = (BIT_W+1)'(tsdx_pkg::V_SHORT_HDR) + (BIT_W+1)'(sig_s4);
		end else begin
			vc   = {shx_s4, sig_s4[5:0], lz_s4, tsdx_pkg::V_LONG_PFX};
			vlen = (BIT_W+1)'(tsdx_pkg::V_LONG_HDR) + (BIT_W+1)'(sig_s4);
		end

		unique case (cls_s4)
			tsdx_pkg::DOD_ZERO: begin
				tc   = '0;
				tlen = (BIT_W+1)'(tsdx_pkg::T_ZERO_LEN);
				body = REC_W'(vc) << tsdx_pkg::T_ZERO_LEN;
			end
			tsdx_pkg::DOD_R1: begin
				tc   = TC_W'({b1_s4, tsdx_pkg::T_R1_PFX});
				tlen = (BIT_W+1)'(tsdx_pkg::T_R1_LEN);
				body = REC_W'(vc) << tsdx_pkg::T_R1_LEN;
			end
			tsdx_pkg::DOD_R2: begin
				tc   = TC_W'({b2_s4, tsdx_pkg::T_R2_PFX});
				tlen = (BIT_W+1)'(tsdx_pkg::T_R2_LEN);
				body = REC_W'(vc) << tsdx_pkg::T_R2_LEN;
			end
			tsdx_pkg::DOD_R3: begin
				tc   = TC_W'({b3_s4, tsdx_pkg::T_R3_PFX});
				tlen = (BIT_W+1)'(tsdx_pkg::T_R3_LEN);
				body = REC_W'(vc) << tsdx_pkg::T_R3_LEN;
			end
			default: begin
				tc   = {dod_s4, tsdx_pkg::T_ESC_PFX};
				tlen = (BIT_W+1)'(tsdx_pkg::T_ESC_LEN);
				body = REC_W'(vc) << tsdx_pkg::T_ESC_LEN;
			end
		endcase
		body = body | REC_W'(tc);

		rec.last = last_s4;
		if (first_s4) begin
			rec.bits = {shx_s4, dod_s4, point_count};
			rec.len  = LEN_W'(tsdx_pkg::HDR_BITS);
		end else begin
			rec.bits = body;
			rec.len  = LEN_W'(tlen) + LEN_W'(vlen);
		end
	end

	assign rec_valid = v_s4;

endmodule

FILE: design/tsdx_queue.sv
// Small FIFO of bit records between the front end and the byte packer.
module tsdx_queue #(
	parameter int DEPTH = tsdx_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tsdx_pkg::rec_t push_rec,
	input  logic           push_valid,
	output logic           push_ready,
	output tsdx_pkg::rec_t pop_rec,
	output logic           pop_valid,
	input  logic           pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	tsdx_pkg::rec_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push, pop;

	assign push_ready = (fill_q != FILL_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

FILE: design/tsdx_back.sv
// Byte packer: merges bit records into an LSB-first stream and drives the byte register.
module tsdx_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsdx_pkg::rec_t              rec,
	input  logic                        rec_valid,
	output logic                        rec_ready,
	output logic [tsdx_pkg::BYTE_W-1:0] out_byte,
	output logic                        last_byte,
	output logic                        byte_valid,
	input  logic                        byte_ready
);

	localparam int ACC_W  = tsdx_pkg::ACC_W;
	localparam int CW     = tsdx_pkg::ACC_CNT_W;
	localparam int BYTE_W = tsdx_pkg::BYTE_W;
	localparam int SH_W   = $clog2(BYTE_W);

	logic [ACC_W-1:0]  acc_q;
	logic [CW-1:0]     cnt_q;
	logic              last_q, busy_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_byte_q, byte_valid_q;
	logic              emit_ok, out_free, load;

	assign emit_ok  = busy_q && ((cnt_q >= CW'(BYTE_W)) || (last_q && (cnt_q != '0)));
	assign out_free = !byte_valid_q || byte_ready;
	assign rec_ready = !emit_ok;
	assign load     = rec_valid && !emit_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			cnt_q        <= '0;
			last_q       <= 1'b0;
			busy_q       <= 1'b0;
			byte_valid_q <= 1'b0;
			out_byte_q   <= '0;
			last_byte_q  <= 1'b0;
		end else begin
			if (emit_ok && out_free) begin
				acc_q <= acc_q >> BYTE_W;
				cnt_q <= (cnt_q > CW'(BYTE_W)) ? cnt_q - CW'(BYTE_W) : '0;
			end else if (load) begin
				acc_q  <= (ACC_W'(rec.bits) << cnt_q[SH_W-1:0])
				          | ACC_W'(acc_q[BYTE_W-2:0]);
				cnt_q  <= cnt_q + CW'(rec.len);
				last_q <= rec.last;
				busy_q <= 1'b1;
			end else if (!emit_ok) begin
				busy_q <= 1'b0;
			end

			if (emit_ok && out_free) begin
				byte_valid_q <= 1'b1;
				out_byte_q   <= acc_q[BYTE_W-1:0];
				last_byte_q  <= last_q && (cnt_q <= CW'(BYTE_W));
			end else if (byte_ready) begin
				byte_valid_q <= 1'b0;
			end
		end
	end

	assign out_byte   = out_byte_q;
	assign last_byte  = last_byte_q;
	assign byte_valid = byte_valid_q;

endmodule

FILE: design/timeseries_delta_xor_encoder_core.sv
// Top level of the time-series delta-of-delta / XOR stream encoder.
//
// Points enter on the point channel (timestamp, sample_bits, last_point; point_valid /
// point_ready) and the compressed stream leaves one byte per beat on the byte channel
// (out_byte, last_byte; byte_valid / byte_ready). Bits fill each byte from bit zero.
// The first point of a series yields the 20-byte header (point_count, timestamp, value);
// later points yield a timestamp code and a value code, 0 to 20 bytes (20 only with the
// final flush). A point flagged last_point flushes the partial byte and its final beat
// carries last_byte. The user must write point_count over the APB port while the block
// is idle; the block itself does not enforce this. A point passes through the four front
// stages and the record queue to the packer; its bytes leave through the byte register.
// The packer loads a record, then emits one byte per cycle while the receiver takes them,
// and takes a new record only once fewer than eight bits remain and no flush is pending.
// The front stages accept a new point every cycle while the queue has
// room. When the receiver stalls, the byte register holds, the packer, queue and front
// stages fill up and point_ready drops.
// Reset clears the series state, the queue and the packer; point_count resets to zero.
module timeseries_delta_xor_encoder_core #(
	parameter int QUEUE_DEPTH = tsdx_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tsdx_pkg::PADDR_W-1:0]   paddr,
	input  logic [tsdx_pkg::PDATA_W-1:0]   pwdata,
	output logic [tsdx_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic [tsdx_pkg::TS_W-1:0]      timestamp,
	input  logic [tsdx_pkg::VAL_W-1:0]     sample_bits,
	input  logic                           last_point,
	input  logic                           point_valid,
	output logic                           point_ready,
	output logic [tsdx_pkg::BYTE_W-1:0]    out_byte,
	output logic                           last_byte,
	output logic                           byte_valid,
	input  logic                           byte_ready
);

	logic [tsdx_pkg::CNT_W-1:0] point_count_q;
	logic                       reg_sel;

	tsdx_pkg::rec_t front_rec, back_rec;
	logic           front_valid, front_ready, back_valid, back_ready;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[tsdx_pkg::PADDR_W-1] == tsdx_pkg::REG_POINT_COUNT);
	assign prdata  = reg_sel ? tsdx_pkg::PDATA_W'(point_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			point_count_q <= pwdata[tsdx_pkg::CNT_W-1:0];
		end
	end

	tsdx_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_count (point_count_q),
		.timestamp   (timestamp),
		.sample_bits (sample_bits),
		.last_point  (last_point),
		.in_valid    (point_valid),
		.in_ready    (point_ready),
		.rec         (front_rec),
		.rec_valid   (front_valid),
		.rec_ready   (front_ready)
	);

	tsdx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_rec   (front_rec),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_rec    (back_rec),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	tsdx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec        (back_rec),
		.rec_valid  (back_valid),
		.rec_ready  (back_ready),
		.out_byte   (out_byte),
		.last_byte  (last_byte),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready)
	);

endmodule
